FILE: src/button_debounce_autorepeat_top_macros.svh
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication.
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bda_pkg.sv
package bda_pkg;

  localparam int LEVEL_BITS   = 8;
  localparam int BTN_IDX_W    = 3;
  localparam int ELAPSED_W    = 8;
  localparam int TIME_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int BUTTONS_DEF  = 8;

  localparam logic [TIME_W-1:0] HOLD_RESET   = 16'd50;
  localparam logic [TIME_W-1:0] DELAY_RESET  = 16'd500;
  localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic [TIME_W-1:0] HELD_MAX     = 16'hffff;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOLD   = 2'd1,
    PH_DELAY  = 2'd2,
    PH_REPEAT = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [BTN_IDX_W-1:0]   latched;
    logic [TIME_W-1:0]      held;
  } key_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
  } timing_t;

endpackage

FILE: src/bda_step.sv
module bda_step #(
  parameter int BUTTONS = bda_pkg::BUTTONS_DEF
) (
  input  bda_pkg::key_state_t                 state,
  input  bda_pkg::timing_t                    timing,
  input  logic [bda_pkg::LEVEL_BITS-1:0]      button_levels,
  input  logic [bda_pkg::BTN_IDX_W-1:0]       polled_button,
  input  logic [bda_pkg::ELAPSED_W-1:0]       elapsed_ms,
  output bda_pkg::key_state_t                 state_nxt,
  output logic                                press_event
);

  logic [bda_pkg::LEVEL_BITS-1:0] present_mask;
  logic [bda_pkg::TIME_W:0]       held_sum;
  logic [bda_pkg::TIME_W-1:0]     held_sat;
  logic [bda_pkg::TIME_W-1:0]     limit;
  logic                           polled_pressed;
  logic                           latched_pressed;
  logic                           due;

  // buttons beyond BUTTONS read as released
  always_comb begin
    for (int i = 0; i < bda_pkg::LEVEL_BITS; i++) begin
      present_mask[i] = (i < BUTTONS);
    end
  end

  assign polled_pressed  = present_mask[polled_button] && !button_levels[polled_button];
  assign latched_pressed = present_mask[state.latched] && !button_levels[state.latched];

  assign held_sum = {1'b0, state.held} + {{(bda_pkg::TIME_W+1-bda_pkg::ELAPSED_W){1'b0}},
                                          elapsed_ms};
  assign held_sat = held_sum[bda_pkg::TIME_W] ? bda_pkg::HELD_MAX
                                              : held_sum[bda_pkg::TIME_W-1:0];

  always_comb begin
    case (state.phase)
      bda_pkg::PH_HOLD:  limit = timing.hold;
      bda_pkg::PH_DELAY: limit = timing.delay;
      default:           limit = timing.period;
    endcase
  end

  assign due = latched_pressed && (polled_button == state.latched) && (held_sat >= limit);

  // next state
  always_comb begin
    state_nxt = state;
    case (state.phase)
      bda_pkg::PH_IDLE: begin
        if (polled_pressed) begin
          state_nxt.phase   = bda_pkg::PH_HOLD;
          state_nxt.latched = polled_button;
          state_nxt.held    = '0;
        end
      end
      bda_pkg::PH_HOLD, bda_pkg::PH_DELAY, bda_pkg::PH_REPEAT: begin
        state_nxt.held = held_sat;
        if (!latched_pressed) begin
          state_nxt.phase = bda_pkg::PH_IDLE;
        end else if (due) begin
          state_nxt.held = '0;
          if (state.phase == bda_pkg::PH_HOLD) begin
            state_nxt.phase = bda_pkg::PH_DELAY;
          end else begin
            state_nxt.phase = bda_pkg::PH_REPEAT;
          end
        end
      end
      default: state_nxt = state;
    endcase
  end

  // outputs
  always_comb begin
    case (state.phase)
      bda_pkg::PH_HOLD, bda_pkg::PH_REPEAT: press_event = due;
      default:                              press_event = 1'b0;
    endcase
  end

endmodule

FILE: src/button_debounce_autorepeat_top.sv
// Button debounce with auto-repeat. Each input item is one poll: active-low
// levels of all buttons, the index of the button polled and the milliseconds
// since the previous poll; each poll yields exactly one item carrying
// press_event. A held button reports a first press after hold_time_ms, arms
// repeat repeat_delay_ms later and then reports every repeat_period_ms; only
// polls of the latched button advance it, releasing it returns to idle.
// Registers (cfg_idx): 0 hold_time_ms, 1 repeat_delay_ms, 2 repeat_period_ms;
// write them only while no poll is in flight. Throughput is one poll per
// cycle when out_ready does not stall the result; a poll passes through the
// input register and the result register around the single update stage.
module button_debounce_autorepeat_top #(
  parameter int BUTTONS = bda_pkg::BUTTONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bda_pkg::LEVEL_BITS-1:0]     in_button_levels,
  input  logic [bda_pkg::BTN_IDX_W-1:0]      in_polled_button,
  input  logic [bda_pkg::ELAPSED_W-1:0]      in_elapsed_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_press_event,
  input  logic                               cfg_we,
  input  logic [bda_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bda_pkg::TIME_W-1:0]         cfg_wdata
);

  logic                            s0_valid_r;
  logic [bda_pkg::LEVEL_BITS-1:0]  s0_levels_r;
  logic [bda_pkg::BTN_IDX_W-1:0]   s0_polled_r;
  logic [bda_pkg::ELAPSED_W-1:0]   s0_elapsed_r;
  bda_pkg::key_state_t             state_r;
  bda_pkg::key_state_t             state_nxt;
  bda_pkg::timing_t                timing_r;
  logic                            out_valid_r;
  logic                            out_event_r;
  logic                            event_nxt;
  logic                            advance;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_levels_r  <= in_button_levels;
      s0_polled_r  <= in_polled_button;
      s0_elapsed_r <= in_elapsed_ms;
    end
  end

  bda_step #(
    .BUTTONS (BUTTONS)
  ) u_step (
    .state         (state_r),
    .timing        (timing_r),
    .button_levels (s0_levels_r),
    .polled_button (s0_polled_r),
    .elapsed_ms    (s0_elapsed_r),
    .state_nxt     (state_nxt),
    .press_event   (event_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= bda_pkg::PH_IDLE;
      state_r.latched <= '0;
      state_r.held    <= '0;
    end else if (s0_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid_r && advance) begin
      out_event_r <= event_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.hold   <= bda_pkg::HOLD_RESET;
      timing_r.delay  <= bda_pkg::DELAY_RESET;
      timing_r.period <= bda_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        bda_pkg::REG_HOLD:   timing_r.hold   <= cfg_wdata;
        bda_pkg::REG_DELAY:  timing_r.delay  <= cfg_wdata;
        bda_pkg::REG_PERIOD: timing_r.period <= cfg_wdata;
        default:             timing_r        <= timing_r;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_press_event = out_event_r;

endmodule

FILE: src/bda_checker.sv
`include "button_debounce_autorepeat_top_macros.svh"

module bda_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_press_event
);

  // a stalled result holds its value
  `BDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_press_event), "result changed while stalled")

  // input side only stalls behind a waiting result
  `BDA_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without a blocked result")

  // nothing comes out straight after reset
  `BDA_ASSERT(a_reset_empty, $rose(rst_n) |-> !out_valid, "result present after reset")

  // an empty pipe accepts
  `BDA_ASSERT_NEXT(a_drain_ready, !in_valid && !out_valid, in_ready, "idle block not ready")

endmodule

bind button_debounce_autorepeat_top bda_checker u_bda_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_press_event (out_press_event)
);
